// ----- hdl/rsht_pkg.sv -----
// Shared types, constants and tables for the rotated shape hit tester.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rsht_pkg;

    localparam int MAX_SHAPES = 64;
    localparam int ENTRY_W = $clog2(MAX_SHAPES);
    localparam int COUNT_W = 7;
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W = $clog2(CORDIC_STEPS);
    localparam int HALF_W = 27;
    localparam int TRIG_W = 27;
    localparam int ZACC_W = 29;
    localparam int OPND_W = 32;
    localparam int PROD_W = 64;
    localparam int REG_ADDR_W = 4;

    localparam int TURN_UNITS = 23040;
    localparam int QUARTER_UNITS = 5760;
    localparam int CORDIC_START = 10188014;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] KIND_RECT = 2'd0;
    localparam logic [1:0] KIND_TRI = 2'd1;
    localparam logic [1:0] KIND_CIRCLE = 2'd2;
    localparam logic [1:0] KIND_QUAD = 2'd3;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_SHAPE_COUNT = 2'd2;

    typedef enum logic [3:0] {
        X_HX, X_HY,
        X_R0X, X_R0Y, X_R1X, X_R1Y, X_R2X, X_R2Y, X_R3X, X_R3Y,
        X_T0, X_T1, X_T2, X_T3
    } xid_t;

    typedef struct packed {
        logic load_we;
        logic query_go;
        logic fetch;
        logic mul_a;
        logic mul_b;
        logic cross_wr;
        xid_t xid;
        logic cordic_start;
        logic res_hit;
        logic res_miss;
        logic ent_dec;
    } dp_cmd_t;

    typedef struct packed {
        logic       empty;
        logic [1:0] kind;
        logic       cordic_busy;
        logic       hit_now;
        logic       ent_zero;
    } dp_stat_t;

    function automatic xid_t xid_succ(input xid_t x);
        return xid_t'(4'(x) + 4'd1);
    endfunction

    function automatic logic xid_last(input xid_t x, input logic [1:0] kind);
        logic last;
        case (kind)
            KIND_CIRCLE: last = (x == X_T1);
            KIND_TRI:    last = (x == X_T2);
            default:     last = (x == X_T3);
        endcase
        return last;
    endfunction

    // Arctangent of 2^-i in degrees, Q.20.
    function automatic logic [25:0] atan_deg(input logic [4:0] i);
        logic [25:0] v;
        case (i)
            5'd0:    v = 26'd47185920;
            5'd1:    v = 26'd27855475;
            5'd2:    v = 26'd14718068;
            5'd3:    v = 26'd7471121;
            5'd4:    v = 26'd3750058;
            5'd5:    v = 26'd1876857;
            5'd6:    v = 26'd938658;
            5'd7:    v = 26'd469357;
            5'd8:    v = 26'd234682;
            5'd9:    v = 26'd117342;
            5'd10:   v = 26'd58671;
            5'd11:   v = 26'd29335;
            5'd12:   v = 26'd14668;
            5'd13:   v = 26'd7334;
            5'd14:   v = 26'd3667;
            5'd15:   v = 26'd1833;
            5'd16:   v = 26'd917;
            5'd17:   v = 26'd458;
            5'd18:   v = 26'd229;
            5'd19:   v = 26'd115;
            5'd20:   v = 26'd57;
            5'd21:   v = 26'd29;
            5'd22:   v = 26'd14;
            5'd23:   v = 26'd7;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/rsht_cordic.sv -----
// Iterative CORDIC unit producing cosine and sine of an angle in 1/64 degree.
// Depends on rsht_pkg.
`timescale 1ns / 1ps

module rsht_cordic
    import rsht_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [14:0]              angle,
    output logic                     busy,
    output logic signed [TRIG_W-1:0] cos_val,
    output logic signed [TRIG_W-1:0] sin_val
);

    logic                     run_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic [1:0]               quad_reg;
    logic signed [TRIG_W-1:0] x_reg;
    logic signed [TRIG_W-1:0] y_reg;
    logic signed [ZACC_W-1:0] z_reg;

    logic [14:0]              a_red;
    logic [1:0]               quad;
    logic [14:0]              rem_full;
    logic [12:0]              rem;
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    logic signed [ZACC_W-1:0] at;

    always_comb
    begin
        a_red = (angle >= 15'(TURN_UNITS)) ? angle - 15'(TURN_UNITS) : angle;
        if (a_red >= 15'(3 * QUARTER_UNITS))
        begin
            quad = 2'd3;
            rem_full = a_red - 15'(3 * QUARTER_UNITS);
        end
        else if (a_red >= 15'(2 * QUARTER_UNITS))
        begin
            quad = 2'd2;
            rem_full = a_red - 15'(2 * QUARTER_UNITS);
        end
        else if (a_red >= 15'(QUARTER_UNITS))
        begin
            quad = 2'd1;
            rem_full = a_red - 15'(QUARTER_UNITS);
        end
        else
        begin
            quad = 2'd0;
            rem_full = a_red;
        end
        rem = rem_full[12:0];
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        at = $signed({3'b000, atan_deg(5'(iter_reg))});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            iter_reg <= '0;
        end
        else if (run_reg)
        begin
            if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
            begin
                run_reg <= 1'b0;
            end
            else
            begin
                iter_reg <= iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quad_reg <= quad;
            x_reg <= TRIG_W'(CORDIC_START);
            y_reg <= '0;
            z_reg <= {2'b00, rem, 14'd0};
        end
        else if (run_reg)
        begin
            if (!z_reg[ZACC_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    always_comb
    begin
        case (quad_reg)
            2'd1:
            begin
                cos_val = -y_reg;
                sin_val = x_reg;
            end
            2'd2:
            begin
                cos_val = -x_reg;
                sin_val = -y_reg;
            end
            2'd3:
            begin
                cos_val = y_reg;
                sin_val = -x_reg;
            end
            default:
            begin
                cos_val = x_reg;
                sin_val = y_reg;
            end
        endcase
    end

    assign busy = run_reg;

endmodule

// ----- hdl/rsht_dp.sv -----
// Datapath: shape table, shared cross-product multiplier, corner registers
// and containment decision. Depends on rsht_pkg and rsht_cordic.
`timescale 1ns / 1ps

module rsht_dp
    import rsht_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [ENTRY_W-1:0] entry_index,
    input  logic [1:0]         shape_kind,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [23:0] size_w,
    input  logic signed [23:0] size_h,
    input  logic [15:0]        scale_x,
    input  logic [15:0]        scale_y,
    input  logic [14:0]        angle,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic signed [23:0] center_x,
    input  logic signed [23:0] center_y,
    input  logic [COUNT_W-1:0] count,
    output logic               hit,
    output logic [ENTRY_W-1:0] hit_index
);

    logic [1:0]  kind_mem  [MAX_SHAPES];
    logic [47:0] pos_mem   [MAX_SHAPES];
    logic [47:0] ext_mem   [MAX_SHAPES];
    logic [31:0] scale_mem [MAX_SHAPES];
    logic [14:0] ang_mem   [MAX_SHAPES];

    logic [1:0]  kind_reg;
    logic [47:0] pos_reg;
    logic [47:0] ext_reg;
    logic [31:0] scale_reg;
    logic [14:0] ang_reg;

    logic [ENTRY_W-1:0]       entry_reg;
    logic signed [23:0]       qx_reg;
    logic signed [23:0]       qy_reg;
    logic signed [HALF_W-1:0] hx_reg;
    logic signed [HALF_W-1:0] hy_reg;
    logic signed [OPND_W-1:0] wx_reg [4];
    logic signed [OPND_W-1:0] wy_reg [4];
    logic signed [PROD_W-1:0] cr_reg [4];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] first_reg;
    logic                     hit_reg;
    logic [ENTRY_W-1:0]       idx_reg;

    logic [COUNT_W-1:0]       n_eff;
    logic                     cordic_busy;
    logic signed [TRIG_W-1:0] co;
    logic signed [TRIG_W-1:0] si;

    logic signed [OPND_W-1:0] px32, py32, dx32, dy32;
    logic signed [OPND_W-1:0] hx32, hy32, nhx, nhy, co32, si32;
    logic signed [OPND_W-1:0] ex [4];
    logic signed [OPND_W-1:0] ey [4];
    logic signed [OPND_W-1:0] rx [4];
    logic signed [OPND_W-1:0] ry [4];
    logic signed [OPND_W-1:0] ax, ay, bx, by;
    logic signed [OPND_W-1:0] mul_opa, mul_opb;
    logic signed [PROD_W-1:0] cross_val;
    logic signed [PROD_W-1:0] shr13, shr24;
    logic [3:0]               xid_bits, r_off, t_off;
    logic [1:0]               r_k, t_idx;
    logic                     r_y;

    logic signed [PROD_W+1:0] tri_d, tri_u, tri_v;
    logic                     tri_hit, quad_hit, circ_hit, hit_now;
    logic                     prev_pos, prev_neg, c_pos, c_neg;

    rsht_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.cordic_start),
        .angle   (ang_reg),
        .busy    (cordic_busy),
        .cos_val (co),
        .sin_val (si)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            kind_mem[entry_index]  <= shape_kind;
            pos_mem[entry_index]   <= {pos_y, pos_x};
            ext_mem[entry_index]   <= {size_h, size_w};
            scale_mem[entry_index] <= {scale_y, scale_x};
            ang_mem[entry_index]   <= angle;
        end
        if (cmd.fetch)
        begin
            kind_reg  <= kind_mem[entry_reg];
            pos_reg   <= pos_mem[entry_reg];
            ext_reg   <= ext_mem[entry_reg];
            scale_reg <= scale_mem[entry_reg];
            ang_reg   <= ang_mem[entry_reg];
        end
    end

    assign n_eff = (count > COUNT_W'(MAX_SHAPES)) ? COUNT_W'(MAX_SHAPES) : count;

    always_comb
    begin
        px32 = 32'(center_x) + 32'($signed(pos_reg[23:0]));
        py32 = 32'(center_y) - 32'($signed(pos_reg[47:24]));
        dx32 = 32'(qx_reg) - px32;
        dy32 = 32'(qy_reg) - py32;
        hx32 = 32'(hx_reg);
        hy32 = 32'(hy_reg);
        nhx = -hx32;
        nhy = -hy32;
        co32 = 32'(co);
        si32 = 32'(si);
        for (int k = 0; k < 4; k++)
        begin
            ex[k] = wx_reg[2'(k + 1)] - wx_reg[k];
            ey[k] = wy_reg[2'(k + 1)] - wy_reg[k];
            rx[k] = 32'(qx_reg) - wx_reg[k];
            ry[k] = 32'(qy_reg) - wy_reg[k];
        end
        xid_bits = cmd.xid;
        r_off = xid_bits - 4'(X_R0X);
        t_off = xid_bits - 4'(X_T0);
        r_k = r_off[2:1];
        r_y = r_off[0];
        t_idx = t_off[1:0];
    end

    // Every product is one cross term a.x * b.y - a.y * b.x.
    always_comb
    begin
        ax = '0;
        ay = '0;
        bx = '0;
        by = '0;
        case (cmd.xid)
            X_HX:
            begin
                ax = 32'($signed(ext_reg[23:0]));
                by = 32'($signed({1'b0, scale_reg[15:0]}));
            end
            X_HY:
            begin
                ax = 32'($signed(ext_reg[47:24]));
                by = 32'($signed({1'b0, scale_reg[31:16]}));
            end
            X_R0X, X_R0Y, X_R1X, X_R1Y, X_R2X, X_R2Y, X_R3X, X_R3Y:
            begin
                ax = (r_k == 2'd0 || r_k == 2'd3) ? nhx : hx32;
                ay = (r_k < 2'd2) ? nhy : hy32;
                if (r_y)
                begin
                    bx = -co32;
                    by = si32;
                end
                else
                begin
                    bx = si32;
                    by = co32;
                end
            end
            X_T0, X_T1, X_T2, X_T3:
            begin
                case (kind_reg)
                    KIND_CIRCLE:
                    begin
                        if (t_idx == 2'd0)
                        begin
                            ax = dx32;
                            ay = dy32;
                            bx = -dy32;
                            by = dx32;
                        end
                        else
                        begin
                            ax = hx32;
                            by = hx32;
                        end
                    end
                    KIND_TRI:
                    begin
                        if (t_idx == 2'd0)
                        begin
                            ax = wx_reg[3] - wx_reg[0];
                            ay = wy_reg[3] - wy_reg[0];
                            bx = wx_reg[1] - wx_reg[0];
                            by = wy_reg[1] - wy_reg[0];
                        end
                        else if (t_idx == 2'd1)
                        begin
                            ax = rx[0];
                            ay = ry[0];
                            bx = wx_reg[1] - wx_reg[0];
                            by = wy_reg[1] - wy_reg[0];
                        end
                        else
                        begin
                            ax = wx_reg[3] - wx_reg[0];
                            ay = wy_reg[3] - wy_reg[0];
                            bx = rx[0];
                            by = ry[0];
                        end
                    end
                    default:
                    begin
                        ax = ex[t_idx];
                        ay = ey[t_idx];
                        bx = rx[t_idx];
                        by = ry[t_idx];
                    end
                endcase
            end
            default:
            begin
                ax = '0;
            end
        endcase
        mul_opa = cmd.mul_a ? ax : ay;
        mul_opb = cmd.mul_a ? by : bx;
        cross_val = first_reg - prod_reg;
        shr13 = cross_val >>> 13;
        shr24 = cross_val >>> 24;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_a || cmd.mul_b)
        begin
            prod_reg <= 64'(mul_opa) * 64'(mul_opb);
        end
        if (cmd.mul_b)
        begin
            first_reg <= prod_reg;
        end
        if (cmd.cross_wr)
        begin
            case (cmd.xid)
                X_HX:
                begin
                    hx_reg <= shr13[HALF_W-1:0];
                end
                X_HY:
                begin
                    hy_reg <= shr13[HALF_W-1:0];
                end
                X_R0X, X_R0Y, X_R1X, X_R1Y, X_R2X, X_R2Y, X_R3X, X_R3Y:
                begin
                    if (r_y)
                    begin
                        wy_reg[r_k] <= py32 + shr24[OPND_W-1:0];
                    end
                    else
                    begin
                        wx_reg[r_k] <= px32 + shr24[OPND_W-1:0];
                    end
                end
                X_T0, X_T1, X_T2, X_T3:
                begin
                    cr_reg[t_idx] <= cross_val;
                end
                default:
                begin
                    cr_reg[0] <= cr_reg[0];
                end
            endcase
        end
        if (cmd.query_go)
        begin
            qx_reg <= point_x;
            qy_reg <= point_y;
            entry_reg <= ENTRY_W'(n_eff - 1'b1);
        end
        else if (cmd.ent_dec)
        begin
            entry_reg <= entry_reg - 1'b1;
        end
    end

    always_comb
    begin
        circ_hit = (cr_reg[0] <= cr_reg[1]);

        if (cr_reg[0] < 0)
        begin
            tri_d = -66'(cr_reg[0]);
            tri_u = -66'(cr_reg[1]);
            tri_v = -66'(cr_reg[2]);
        end
        else
        begin
            tri_d = 66'(cr_reg[0]);
            tri_u = 66'(cr_reg[1]);
            tri_v = 66'(cr_reg[2]);
        end
        tri_hit = (cr_reg[0] != 0) && (tri_u >= 0) && (tri_v >= 0)
                  && (tri_u + tri_v <= tri_d);

        quad_hit = 1'b1;
        prev_neg = cr_reg[0][PROD_W-1];
        prev_pos = !cr_reg[0][PROD_W-1] && (cr_reg[0] != 0);
        for (int k = 1; k < 4; k++)
        begin
            c_neg = cr_reg[k][PROD_W-1];
            c_pos = !cr_reg[k][PROD_W-1] && (cr_reg[k] != 0);
            if ((prev_neg && c_pos) || (prev_pos && c_neg))
            begin
                quad_hit = 1'b0;
            end
            if (c_neg || c_pos)
            begin
                prev_neg = c_neg;
                prev_pos = c_pos;
            end
        end

        case (kind_reg)
            KIND_CIRCLE: hit_now = circ_hit;
            KIND_TRI:    hit_now = tri_hit;
            default:     hit_now = quad_hit;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (cmd.res_hit)
        begin
            hit_reg <= 1'b1;
            idx_reg <= entry_reg;
        end
        else if (cmd.res_miss)
        begin
            hit_reg <= 1'b0;
            idx_reg <= '0;
        end
    end

    assign stat.empty = (n_eff == '0);
    assign stat.kind = kind_reg;
    assign stat.cordic_busy = cordic_busy;
    assign stat.hit_now = hit_now;
    assign stat.ent_zero = (entry_reg == '0);

    assign hit = hit_reg;
    assign hit_index = idx_reg;

    a_cordic_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cordic_start |-> !cordic_busy)
        else $error("CORDIC restarted while running");

endmodule

// ----- hdl/rsht_ctrl.sv -----
// Controller state machine: accepts commands, sequences the per-entry
// cross products and CORDIC run, and issues the result beat. Depends on rsht_pkg.
`timescale 1ns / 1ps

module rsht_ctrl
    import rsht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     opcode,
    output logic     busy,
    output logic     done,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FETCH  = 6'b000010,
        ST_CROSS  = 6'b000100,
        ST_CORDIC = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_W = 2'd2;

    state_t     state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    xid_t       xid_reg, xid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_A;
            xid_reg <= X_HX;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            xid_reg <= xid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        xid_next = xid_reg;
        cmd = '0;
        cmd.xid = xid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.query_go = 1'b1;
                        if (stat.empty)
                        begin
                            cmd.res_miss = 1'b1;
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                xid_next = X_HX;
                phase_next = PH_A;
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                case (phase_reg)
                    PH_A:
                    begin
                        cmd.mul_a = 1'b1;
                        phase_next = PH_B;
                    end
                    PH_B:
                    begin
                        cmd.mul_b = 1'b1;
                        phase_next = PH_W;
                    end
                    default:
                    begin
                        cmd.cross_wr = 1'b1;
                        phase_next = PH_A;
                        if (xid_reg == X_HY)
                        begin
                            cmd.cordic_start = 1'b1;
                            xid_next = X_R0X;
                            state_next = ST_CORDIC;
                        end
                        else if (xid_last(xid_reg, stat.kind))
                        begin
                            state_next = ST_DECIDE;
                        end
                        else
                        begin
                            xid_next = xid_succ(xid_reg);
                        end
                    end
                endcase
            end
            ST_CORDIC:
            begin
                if (!stat.cordic_busy)
                begin
                    state_next = ST_CROSS;
                end
            end
            ST_DECIDE:
            begin
                if (stat.hit_now)
                begin
                    cmd.res_hit = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (stat.ent_zero)
                begin
                    cmd.res_miss = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.ent_dec = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_RESULT);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result beat lasted more than one cycle");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_LOAD) |=> !busy)
        else $error("Load beat made the block busy");

    a_fetch_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_QUERY && !stat.empty) |=> cmd.fetch)
        else $error("Query did not start a table walk");

endmodule

// ----- hdl/rotated_shape_hit_tester_core.sv -----
// Top level of the rotated shape hit tester: configuration registers on the
// APB-style port, controller and datapath. Depends on rsht_pkg, rsht_ctrl, rsht_dp.
`timescale 1ns / 1ps

// A load beat writes one table entry; busy stays low.
// A query beat walks the entries from min(shape_count, MAX_SHAPES)-1 down and
// stops at the first hit. For each entry visited the controller fetches it,
// forms the two scaled half extents, runs the iterative CORDIC unit, forms the
// eight rotated corner coordinates and then T containment cross products, where
// T is 2 for a circle, 3 for a triangle and 4 for a rectangle or textured quad,
// each product on the one shared 32x32 multiplier in turn, and then decides.
// The result beat is shown for exactly one cycle on done; the receiver cannot
// stall it, so it must sample hit and hit_index whenever done is high.

module rotated_shape_hit_tester_core
    import rsht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic                  opcode,
    input  logic [ENTRY_W-1:0]    entry_index,
    input  logic [1:0]            shape_kind,
    input  logic signed [23:0]    pos_x,
    input  logic signed [23:0]    pos_y,
    input  logic signed [23:0]    size_w,
    input  logic signed [23:0]    size_h,
    input  logic [15:0]           scale_x,
    input  logic [15:0]           scale_y,
    input  logic [14:0]           angle,
    input  logic signed [23:0]    point_x,
    input  logic signed [23:0]    point_y,
    output logic                  done,
    output logic                  hit,
    output logic [ENTRY_W-1:0]    hit_index
);

    logic [23:0]        cx_reg;
    logic [23:0]        cy_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               cfg_we;
    dp_cmd_t            cmd;
    dp_stat_t           stat;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_CENTER_X:    cx_reg <= pwdata[23:0];
                REG_CENTER_Y:    cy_reg <= pwdata[23:0];
                REG_SHAPE_COUNT: cnt_reg <= pwdata[COUNT_W-1:0];
                default:         cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CENTER_X:    prdata = 32'(cx_reg);
            REG_CENTER_Y:    prdata = 32'(cy_reg);
            REG_SHAPE_COUNT: prdata = 32'(cnt_reg);
            default:         prdata = '0;
        endcase
    end

    rsht_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .stat   (stat)
    );

    rsht_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .entry_index (entry_index),
        .shape_kind  (shape_kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .size_w      (size_w),
        .size_h      (size_h),
        .scale_x     (scale_x),
        .scale_y     (scale_y),
        .angle       (angle),
        .point_x     (point_x),
        .point_y     (point_y),
        .center_x    ($signed(cx_reg)),
        .center_y    ($signed(cy_reg)),
        .count       (cnt_reg),
        .hit         (hit),
        .hit_index   (hit_index)
    );

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (hit_index == '0))
        else $error("Miss reported with a nonzero index");

endmodule

// ----- tb/rotated_shape_hit_tester_core_tb.sv -----
// Testbench for rotated_shape_hit_tester_core: loads shape entries, writes the canvas
// registers over the APB-style port and checks every query beat against a local predictor.
// Depends on rsht_pkg and the core RTL only.
`timescale 1ns / 1ps

module rotated_shape_hit_tester_core_tb;
    import rsht_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]         kind;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] w;
        logic signed [23:0] h;
        logic [15:0]        sx;
        logic [15:0]        sy;
        logic [14:0]        ang;
    } shape_t;

    typedef struct {
        logic                hit;
        logic [ENTRY_W-1:0]  idx;
    } pick_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [REG_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic opcode = OP_LOAD;
    logic [ENTRY_W-1:0] entry_index = '0;
    logic [1:0] shape_kind = KIND_RECT;
    logic signed [23:0] pos_x = '0, pos_y = '0, size_w = '0, size_h = '0;
    logic [15:0] scale_x = '0, scale_y = '0;
    logic [14:0] angle = '0;
    logic signed [23:0] point_x = '0, point_y = '0;
    logic done;
    logic hit;
    logic [ENTRY_W-1:0] hit_index;

    shape_t shape_table [MAX_SHAPES];
    logic signed [23:0] center_x = '0;
    logic signed [23:0] center_y = '0;
    logic [6:0] live_count = '0;
    pick_t pending_picks [$];
    int errors = 0;
    int idle_cycles = 0;
    int items_sent = 0;

    rotated_shape_hit_tester_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .opcode(opcode), .entry_index(entry_index), .shape_kind(shape_kind),
        .pos_x(pos_x), .pos_y(pos_y), .size_w(size_w), .size_h(size_h),
        .scale_x(scale_x), .scale_y(scale_y), .angle(angle),
        .point_x(point_x), .point_y(point_y),
        .done(done), .hit(hit), .hit_index(hit_index)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void rotation(input logic [14:0] ang, output longint co,
                                     output longint si);
        longint x, y, z, dx, dy;
        int unsigned a, q, r;
        int i;
        a = ang % TURN_UNITS;
        q = a / QUARTER_UNITS;
        r = a % QUARTER_UNITS;
        x = CORDIC_START;
        y = 0;
        z = longint'(r) <<< 14;
        for (i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - longint'(atan_deg(5'(i)));
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + longint'(atan_deg(5'(i)));
            end
        end
        case (q)
            1: begin co = -y; si = x; end
            2: begin co = -x; si = -y; end
            3: begin co = y; si = -x; end
            default: begin co = x; si = y; end
        endcase
    endfunction

    function automatic bit shape_covers(input int e, input longint qx, input longint qy);
        shape_t s;
        longint px, py, hx, hy, co, si, d, u, v, cr, prev;
        longint ux[4], uy[4], wx[4], wy[4];
        int k, n;
        s = shape_table[e];
        px = longint'(center_x) + longint'(s.px);
        py = longint'(center_y) - longint'(s.py);
        hx = (longint'(s.w) * longint'(s.sx)) >>> 13;
        hy = (longint'(s.h) * longint'(s.sy)) >>> 13;
        ux[0] = -hx; uy[0] = -hy;
        ux[1] = hx;  uy[1] = -hy;
        ux[2] = hx;  uy[2] = hy;
        ux[3] = -hx; uy[3] = hy;
        rotation(s.ang, co, si);
        for (k = 0; k < 4; k++)
        begin
            wx[k] = px + ((ux[k] * co - uy[k] * si) >>> 24);
            wy[k] = py + ((ux[k] * si + uy[k] * co) >>> 24);
        end
        if (s.kind == KIND_CIRCLE)
            return (qx - px) * (qx - px) + (qy - py) * (qy - py) <= hx * hx;
        if (s.kind == KIND_TRI)
        begin
            d = (wx[3] - wx[0]) * (wy[1] - wy[0]) - (wy[3] - wy[0]) * (wx[1] - wx[0]);
            u = (qx - wx[0]) * (wy[1] - wy[0]) - (qy - wy[0]) * (wx[1] - wx[0]);
            v = (wx[3] - wx[0]) * (qy - wy[0]) - (wy[3] - wy[0]) * (qx - wx[0]);
            if (d == 0)
                return 1'b0;
            if (d < 0)
            begin
                d = -d; u = -u; v = -v;
            end
            return u >= 0 && v >= 0 && u + v <= d;
        end
        prev = 0;
        for (k = 0; k < 4; k++)
        begin
            n = (k + 1) & 3;
            cr = (wx[n] - wx[k]) * (qy - wy[k]) - (wy[n] - wy[k]) * (qx - wx[k]);
            if (k == 0)
                prev = cr;
            else
            begin
                if ((prev < 0 && cr > 0) || (prev > 0 && cr < 0))
                    return 1'b0;
                if (cr != 0)
                    prev = cr;
            end
        end
        return 1'b1;
    endfunction

    function automatic pick_t topmost_hit(input logic signed [23:0] qx,
                                          input logic signed [23:0] qy);
        pick_t p;
        int n;
        p.hit = 1'b0;
        p.idx = '0;
        n = (live_count > MAX_SHAPES) ? MAX_SHAPES : live_count;
        while (n > 0)
        begin
            n--;
            if (shape_covers(n, longint'(qx), longint'(qy)))
            begin
                p.hit = 1'b1;
                p.idx = ENTRY_W'(n);
                break;
            end
        end
        return p;
    endfunction

    task automatic send_beat(input logic op, input logic [ENTRY_W-1:0] idx, input shape_t s,
                             input logic signed [23:0] qx, input logic signed [23:0] qy);
        pick_t want;
        @(negedge clk);
        start = 1'b1;
        opcode = op;
        entry_index = idx;
        shape_kind = s.kind;
        pos_x = s.px; pos_y = s.py; size_w = s.w; size_h = s.h;
        scale_x = s.sx; scale_y = s.sy; angle = s.ang;
        point_x = qx; point_y = qy;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (op == OP_LOAD)
            shape_table[idx] = s;
        else
        begin
            want = topmost_hit(qx, qy);
            pending_picks.insert(pending_picks.size(), want);
        end
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drain_results();
        pause_sender(0);
        wait (pending_picks.size() == 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = REG_ADDR_W'({idx, 2'b00});
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_CENTER_X: center_x = value[23:0];
            REG_CENTER_Y: center_y = value[23:0];
            default:      live_count = value[6:0];
        endcase
    endtask

    task automatic set_canvas(input logic signed [23:0] cx, input logic signed [23:0] cy,
                              input logic [6:0] count);
        write_reg(REG_CENTER_X, 32'(cx));
        write_reg(REG_CENTER_Y, 32'(cy));
        write_reg(REG_SHAPE_COUNT, 32'(count));
    endtask

    function automatic shape_t random_shape(input bit wild);
        shape_t s;
        s.kind = 2'($urandom_range(0, 3));
        if (wild)
        begin
            s.px = 24'($urandom); s.py = 24'($urandom);
            s.w = 24'($urandom); s.h = 24'($urandom);
            s.sx = 16'($urandom_range(0, 40960)); s.sy = 16'($urandom_range(0, 40960));
            s.ang = 15'($urandom);
        end
        else
        begin
            s.px = 24'($signed($urandom_range(0, 131072)) - 65536);
            s.py = 24'($signed($urandom_range(0, 131072)) - 65536);
            s.w = 24'($signed($urandom_range(0, 12288)) - 2048);
            s.h = 24'($signed($urandom_range(0, 12288)) - 2048);
            s.sx = 16'($urandom_range(1024, 12288)); s.sy = 16'($urandom_range(1024, 12288));
            s.ang = 15'($urandom_range(0, TURN_UNITS - 1));
        end
        return s;
    endfunction

    task automatic query_near(input int e, input int spread);
        shape_t s;
        longint qx, qy;
        s = shape_table[e];
        qx = longint'(center_x) + longint'(s.px) + $signed($urandom_range(0, 2 * spread)) - spread;
        qy = longint'(center_y) - longint'(s.py) + $signed($urandom_range(0, 2 * spread)) - spread;
        send_beat(OP_QUERY, '0, s, 24'(qx), 24'(qy));
    endtask

    task automatic test_fill_table();
        int e;
        for (e = 0; e < MAX_SHAPES; e++)
            send_beat(OP_LOAD, ENTRY_W'(e), random_shape(1'b0), '0, '0);
        drain_results();
    endtask

    task automatic test_directed();
        shape_t s;
        s = '{KIND_RECT, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'd4096, 16'd4096, 15'd0};
        send_beat(OP_LOAD, 6'd0, s, '0, '0);
        s = '{KIND_TRI, 24'sd256, 24'sd256, 24'sd0, 24'sd2560, 16'd4096, 16'd4096, 15'd100};
        send_beat(OP_LOAD, 6'd1, s, '0, '0);
        s = '{KIND_CIRCLE, 24'sd0, 24'sd0, 24'sd2560, 24'sd0, 16'd4096, 16'd0, 15'd0};
        send_beat(OP_LOAD, 6'd2, s, '0, '0);
        s = '{KIND_QUAD, 24'sd0, 24'sd0, 24'sd5120, 24'sd2560, 16'd40960, 16'd40960, 15'h7fff};
        send_beat(OP_LOAD, 6'd3, s, '0, '0);
        s = '{KIND_TRI, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh800000,
              16'd40960, 16'd40960, 15'd23039};
        send_beat(OP_LOAD, 6'd62, s, '0, '0);
        s = '{KIND_RECT, 24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff,
              16'd0, 16'd65535 & 16'd40960, 15'd5760};
        send_beat(OP_LOAD, 6'd63, s, '0, '0);
        drain_results();
        set_canvas(24'sd0, 24'sd0, 7'd4);
        send_beat(OP_QUERY, '0, s, 24'sd0, 24'sd0);
        send_beat(OP_QUERY, '0, s, 24'sd2000, -24'sd100);
        send_beat(OP_QUERY, '0, s, 24'sd300, 24'sd2000);
        send_beat(OP_QUERY, '0, s, 24'sh7fffff, 24'sh800000);
        drain_results();
        set_canvas(24'sd0, 24'sd0, 7'd3);
        send_beat(OP_QUERY, '0, s, 24'sd100, -24'sd400);
        send_beat(OP_QUERY, '0, s, 24'sh800000, 24'sh7fffff);
        drain_results();
        set_canvas(24'sh7fffff, 24'sh800000, 7'd127);
        send_beat(OP_QUERY, '0, s, 24'sh7fffff, 24'sh800000);
        send_beat(OP_QUERY, '0, s, 24'sd0, 24'sd0);
        drain_results();
        set_canvas(24'sh800000, 24'sh7fffff, 7'd64);
        send_beat(OP_QUERY, '0, s, 24'sh800000, 24'sh7fffff);
        drain_results();
        set_canvas(24'sd0, 24'sd0, 7'd0);
        send_beat(OP_QUERY, '0, s, 24'sd0, 24'sd0);
        drain_results();
    endtask

    task automatic test_random();
        int burst, k, phase_left, count, r;
        phase_left = 0;
        while (items_sent < 800)
        begin
            if (phase_left == 0)
            begin
                drain_results();
                r = $urandom_range(0, 9);
                count = (r == 0) ? 64 : (r == 1) ? $urandom_range(65, 127) :
                        $urandom_range(1, 12);
                set_canvas(24'($signed($urandom_range(0, 2097152)) - 1048576),
                           24'($signed($urandom_range(0, 2097152)) - 1048576), 7'(count));
                phase_left = (count >= 64) ? 12 : 120;
            end
            burst = $urandom_range(1, 10);
            for (k = 0; k < burst && phase_left > 0; k++)
            begin
                phase_left--;
                r = $urandom_range(0, 19);
                if (r < 6)
                    send_beat(OP_LOAD, ENTRY_W'($urandom), random_shape(r == 0), '0, '0);
                else if (r < 18)
                    query_near($urandom_range(0, (live_count > MAX_SHAPES ? MAX_SHAPES :
                               (live_count == 0 ? 1 : live_count)) - 1),
                               (r & 1) ? 1024 : 4096);
                else
                    send_beat(OP_QUERY, '0, shape_table[0], 24'($urandom), 24'($urandom));
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(0, 12));
        end
        drain_results();
    endtask

    always @(posedge clk)
    begin
        pick_t want;
        if (rst_n && done)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("result beat with nothing expected: hit=%0d hit_index=%0d",
                       hit, hit_index);
                errors++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, hit);
                    errors++;
                end
                if (hit_index !== want.idx)
                begin
                    $error("hit_index: expected %0d, got %0d", want.idx, hit_index);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("[rotated_shape_hit_tester_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_fill_table();
        test_directed();
        test_random();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending_picks.size() == 0)
            $display("[rotated_shape_hit_tester_core] OK");
        else
            $display("[rotated_shape_hit_tester_core] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/rsht_pkg.sv
hdl/rsht_cordic.sv
hdl/rsht_dp.sv
hdl/rsht_ctrl.sv
hdl/rotated_shape_hit_tester_core.sv
tb/rotated_shape_hit_tester_core_tb.sv
